// ----- hdl/stippled_segment_walker_defines.svh -----
// ----------------------------------------------------------------------------
// stippled_segment_walker_defines
// assertion macros shared by the segment walker rtl
// ----------------------------------------------------------------------------
`ifndef STIPPLED_SEGMENT_WALKER_DEFINES_SVH
`define STIPPLED_SEGMENT_WALKER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SSW_ASSERT_NOW(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("segment walker check failed");

// condition holds in the cycle after the trigger
`define SSW_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("segment walker check failed");

`endif

// ----- hdl/ssw_pkg.sv -----
// ----------------------------------------------------------------------------
// ssw_pkg
// shared types, codes and the microcode table of the segment walker
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int DEF_MAX_LENGTH = 63;
    localparam int DEF_COORD_BITS = 12;

    localparam int LEN_BITS    = 6;
    localparam int PHASE_BITS  = 5;
    localparam int COLOUR_BITS = 16;
    localparam int KIND_BITS   = 2;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;
    localparam int UPC_BITS    = 1;

    // segment kinds
    localparam logic [KIND_BITS-1:0] KIND_VERT  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LEFT  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RIGHT = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd3;

    // register indexes (paddr word offset)
    localparam logic [2:0] REG_COLOUR_FIRST  = 3'd0;
    localparam logic [2:0] REG_COLOUR_SECOND = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT     = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP      = 3'd3;
    localparam logic [2:0] REG_CLIP_RIGHT    = 3'd4;
    localparam logic [2:0] REG_CLIP_BOTTOM   = 3'd5;
    localparam logic [2:0] REG_PATTERN_MODE  = 3'd6;

    // microcode step addresses
    localparam logic [UPC_BITS-1:0] UPC_IDLE = 1'b0;
    localparam logic [UPC_BITS-1:0] UPC_WALK = 1'b1;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_NO_WALK  = 2'd1,
        COND_NOT_DONE = 2'd2
    } cond_t;

    typedef struct packed {
        logic                take_cmd;
        logic                emit;
        cond_t               cond;
        logic [UPC_BITS-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic cmd_fire;
        logic walk_ok;
        logic emit_fire;
        logic last;
    } seq_status_t;

    // control store: idle waits for a walkable command, walk emits until the
    // last step, then falls through and the counter wraps back to idle
    function automatic ucode_t ucode_rom(input logic [UPC_BITS-1:0] upc);
        ucode_t w;
        begin
            w = '{take_cmd: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: UPC_IDLE};
            case (upc)
                UPC_IDLE: w = '{take_cmd: 1'b1, emit: 1'b0, cond: COND_NO_WALK,
                                target: UPC_IDLE};
                UPC_WALK: w = '{take_cmd: 1'b0, emit: 1'b1, cond: COND_NOT_DONE,
                                target: UPC_WALK};
                default:  w = '{take_cmd: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
                                target: UPC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- hdl/ssw_sequencer.sv -----
// ----------------------------------------------------------------------------
// ssw_sequencer
// step counter and control store that drive the walker datapath
// ----------------------------------------------------------------------------
module ssw_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssw_pkg::seq_status_t status,
    output ssw_pkg::ucode_t      ctl
);
    import ssw_pkg::*;

    logic [UPC_BITS-1:0] upc_reg;
    logic [UPC_BITS-1:0] upc_next;
    logic                jump;

    assign ctl = ucode_rom(upc_reg);

    always_comb begin
        case (ctl.cond)
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_WALK:  jump = !(status.cmd_fire && status.walk_ok);
            COND_NOT_DONE: jump = !(status.emit_fire && status.last);
            default:       jump = 1'b0;
        endcase
        upc_next = jump ? ctl.target : upc_reg + UPC_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- hdl/stippled_segment_walker.sv -----
// ----------------------------------------------------------------------------
// stippled_segment_walker
// marching-ants edge walker: one segment command in, one pixel step per result
// ----------------------------------------------------------------------------
// A command (kind, start point, length, phase) is a transfer on the s_ channel;
// each walked pixel leaves as one transfer on the m_ channel with the main and
// neighbour coordinates, colour, write enables and a last-step flag.
// Vertical commands give length steps, diagonal ones length+1; kind none and
// vertical length zero give nothing.
// s_ready is high only while the sequencer sits in its idle step. Once a command
// is taken, one step is emitted per cycle while the output register is free or
// m_ready is high; the walk loop of the control store emits up to 64 steps per
// segment. The first result passes the sequencer's walk step and then the output
// register before it is visible.
// A stalled receiver (m_ready low) freezes the walk; the output register and
// its payload hold until the transfer completes.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops
// m_valid and clears the clip, colour and mode registers.
// Configuration is an APB-style port; registers sit at 4*index and are meant
// to be written only while no segment is in flight.
// ----------------------------------------------------------------------------
`include "stippled_segment_walker_defines.svh"

module stippled_segment_walker #(
    parameter int MAX_LENGTH = ssw_pkg::DEF_MAX_LENGTH,
    parameter int COORD_BITS = ssw_pkg::DEF_COORD_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssw_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ssw_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [ssw_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    // command channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ssw_pkg::KIND_BITS-1:0]     s_kind,
    input  logic signed [COORD_BITS-1:0]      s_start_x,
    input  logic signed [COORD_BITS-1:0]      s_start_y,
    input  logic [ssw_pkg::LEN_BITS-1:0]      s_length,
    input  logic [ssw_pkg::PHASE_BITS-1:0]    s_phase,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [COORD_BITS-1:0]      m_pix_x,
    output logic signed [COORD_BITS-1:0]      m_pix_y,
    output logic signed [COORD_BITS-1:0]      m_side_x,
    output logic signed [COORD_BITS-1:0]      m_side_y,
    output logic [ssw_pkg::COLOUR_BITS-1:0]   m_colour,
    output logic                              m_write_main,
    output logic                              m_write_side,
    output logic                              m_last_step
);
    import ssw_pkg::*;

    localparam int STEP_BITS = $clog2(MAX_LENGTH + 2);

    // configuration registers
    logic [COLOUR_BITS-1:0]       colour_first_reg;
    logic [COLOUR_BITS-1:0]       colour_second_reg;
    logic signed [COORD_BITS-1:0] clip_left_reg;
    logic signed [COORD_BITS-1:0] clip_top_reg;
    logic signed [COORD_BITS-1:0] clip_right_reg;
    logic signed [COORD_BITS-1:0] clip_bottom_reg;
    logic                         pattern_mode_reg;

    logic                         cfg_wr;
    logic [2:0]                   cfg_idx;

    // walk state
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [PHASE_BITS-1:0]        cur_phase_reg, cur_phase_next;
    logic                         odd_step_reg, odd_step_next;
    logic [STEP_BITS-1:0]         steps_left_reg, steps_left_next;
    logic [KIND_BITS-1:0]         walk_kind_reg, walk_kind_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic signed [COORD_BITS-1:0] pix_x_reg, pix_y_reg, side_x_reg, side_y_reg;
    logic [COLOUR_BITS-1:0]       colour_reg;
    logic                         write_main_reg, write_side_reg, last_step_reg;

    ucode_t                       ctl;
    seq_status_t                  status;

    logic                         cmd_fire;
    logic                         walk_ok;
    logic                         emit_fire;
    logic                         last;
    logic [LEN_BITS:0]            len_ext;
    logic [STEP_BITS-1:0]         len_sat;
    logic [STEP_BITS-1:0]         steps_init;

    logic                         in_clip;
    logic [COLOUR_BITS-1:0]       step_colour;
    logic                         paint;
    logic                         side_ok;
    logic signed [COORD_BITS-1:0] step_side_x, step_side_y;
    logic [3:0]                   ph_solid;

    // ---------------------------------------------------------------- config
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_first_reg  <= '0;
            colour_second_reg <= '0;
            clip_left_reg     <= '0;
            clip_top_reg      <= '0;
            clip_right_reg    <= '0;
            clip_bottom_reg   <= '0;
            pattern_mode_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COLOUR_FIRST:  colour_first_reg  <= pwdata[COLOUR_BITS-1:0];
                REG_COLOUR_SECOND: colour_second_reg <= pwdata[COLOUR_BITS-1:0];
                REG_CLIP_LEFT:     clip_left_reg     <= pwdata[COORD_BITS-1:0];
                REG_CLIP_TOP:      clip_top_reg      <= pwdata[COORD_BITS-1:0];
                REG_CLIP_RIGHT:    clip_right_reg    <= pwdata[COORD_BITS-1:0];
                REG_CLIP_BOTTOM:   clip_bottom_reg   <= pwdata[COORD_BITS-1:0];
                REG_PATTERN_MODE:  pattern_mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COLOUR_FIRST:  prdata = PDATA_BITS'(colour_first_reg);
            REG_COLOUR_SECOND: prdata = PDATA_BITS'(colour_second_reg);
            REG_CLIP_LEFT:     prdata = PDATA_BITS'($unsigned(clip_left_reg));
            REG_CLIP_TOP:      prdata = PDATA_BITS'($unsigned(clip_top_reg));
            REG_CLIP_RIGHT:    prdata = PDATA_BITS'($unsigned(clip_right_reg));
            REG_CLIP_BOTTOM:   prdata = PDATA_BITS'($unsigned(clip_bottom_reg));
            REG_PATTERN_MODE:  prdata = PDATA_BITS'(pattern_mode_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- sequencer
    assign s_ready   = ctl.take_cmd;
    assign cmd_fire  = s_valid && s_ready;
    assign walk_ok   = (s_kind != KIND_NONE) &&
                       !((s_kind == KIND_VERT) && (s_length == '0));
    assign emit_fire = ctl.emit && (!m_valid_reg || m_ready);
    assign last      = (steps_left_reg == STEP_BITS'(1));

    assign status = '{cmd_fire: cmd_fire, walk_ok: walk_ok,
                      emit_fire: emit_fire, last: last};

    ssw_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctl     (ctl)
    );

    // ------------------------------------------------------------- step logic
    assign len_ext    = {1'b0, s_length};
    assign len_sat    = (len_ext > (LEN_BITS+1)'(MAX_LENGTH)) ? STEP_BITS'(MAX_LENGTH)
                                                              : STEP_BITS'(len_ext);
    assign steps_init = (s_kind == KIND_VERT) ? len_sat : len_sat + STEP_BITS'(1);

    assign in_clip = (cur_x_reg >= clip_left_reg) && (cur_x_reg < clip_right_reg) &&
                     (cur_y_reg >= clip_top_reg)  && (cur_y_reg < clip_bottom_reg);

    assign ph_solid = cur_phase_reg[3:0];

    always_comb begin
        if (pattern_mode_reg) begin
            if (cur_phase_reg inside {[5'd12:5'd15]}) begin
                step_colour = colour_first_reg;
            end else if (cur_phase_reg inside {[5'd28:5'd31]}) begin
                step_colour = colour_second_reg;
            end else begin
                step_colour = '0;
            end
        end else begin
            step_colour = (ph_solid < 4'd12) ? colour_first_reg : colour_second_reg;
        end
    end

    assign paint = in_clip && (!pattern_mode_reg || (step_colour != '0));

    // neighbour: left of the pixel when vertical, above it when diagonal
    always_comb begin
        if (walk_kind_reg == KIND_VERT) begin
            step_side_x = cur_x_reg - COORD_BITS'(1);
            step_side_y = cur_y_reg;
            side_ok     = !cur_x_reg[COORD_BITS-1] && (cur_x_reg != '0);
        end else begin
            step_side_x = cur_x_reg;
            step_side_y = cur_y_reg - COORD_BITS'(1);
            side_ok     = !cur_y_reg[COORD_BITS-1] && (cur_y_reg != '0);
        end
    end

    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_phase_next  = cur_phase_reg;
        odd_step_next   = odd_step_reg;
        steps_left_next = steps_left_reg;
        walk_kind_next  = walk_kind_reg;
        if (cmd_fire && walk_ok) begin
            cur_x_next      = s_start_x;
            cur_y_next      = s_start_y;
            cur_phase_next  = s_phase;
            odd_step_next   = 1'b0;
            steps_left_next = steps_init;
            walk_kind_next  = s_kind;
        end else if (emit_fire) begin
            if (walk_kind_reg == KIND_VERT) begin
                cur_y_next = cur_y_reg - COORD_BITS'(1);
            end else begin
                cur_x_next = (walk_kind_reg == KIND_LEFT) ? cur_x_reg - COORD_BITS'(1)
                                                          : cur_x_reg + COORD_BITS'(1);
                // y rises after every second diagonal step
                if (odd_step_reg) begin
                    cur_y_next = cur_y_reg + COORD_BITS'(1);
                end
                odd_step_next = !odd_step_reg;
            end
            cur_phase_next  = cur_phase_reg + PHASE_BITS'(1);
            steps_left_next = steps_left_reg - STEP_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_phase_reg  <= '0;
            odd_step_reg   <= 1'b0;
            steps_left_reg <= '0;
            walk_kind_reg  <= KIND_VERT;
        end else begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            cur_phase_reg  <= cur_phase_next;
            odd_step_reg   <= odd_step_next;
            steps_left_reg <= steps_left_next;
            walk_kind_reg  <= walk_kind_next;
        end
    end

    // --------------------------------------------------------- output register
    always_comb begin
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            pix_x_reg      <= cur_x_reg;
            pix_y_reg      <= cur_y_reg;
            side_x_reg     <= step_side_x;
            side_y_reg     <= step_side_y;
            colour_reg     <= step_colour;
            write_main_reg <= paint;
            write_side_reg <= paint && side_ok;
            last_step_reg  <= last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pix_x      = pix_x_reg;
    assign m_pix_y      = pix_y_reg;
    assign m_side_x     = side_x_reg;
    assign m_side_y     = side_y_reg;
    assign m_colour     = colour_reg;
    assign m_write_main = write_main_reg;
    assign m_write_side = write_side_reg;
    assign m_last_step  = last_step_reg;

    // -------------------------------------------------------------- checks
    `SSW_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, emit_fire && last, s_ready)
    `SSW_ASSERT_NEXT(a_busy_after_cmd, aclk, aresetn, cmd_fire && walk_ok, !s_ready)
    `SSW_ASSERT_NOW(a_steps_while_walk, aclk, aresetn, ctl.emit, steps_left_reg != '0)

endmodule
